### rtl/emboss_3x3_image_filter_defines.svh
`ifndef EMBOSS_3X3_IMAGE_FILTER_DEFINES_SVH
`define EMBOSS_3X3_IMAGE_FILTER_DEFINES_SVH

// checked property, off while reset is asserted
`define EMB3_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("emboss filter check failed");

// checked property, also during reset
`define EMB3_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("emboss filter check failed");

`endif

### rtl/emb3_pkg.sv
`timescale 1ns / 1ps
package emb3_pkg;

  localparam int PIX_W         = 8;
  localparam int COORD_W       = 12;
  localparam int CFG_W         = 13;
  localparam int LINE_W        = 2 * PIX_W;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_LINES_DEF = 4096;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(640);
  localparam int               MIN_WIDTH      = 3;

  // sum of six taps plus bias stays within 0..1530
  localparam int SUM_W    = 11;
  localparam int EMB_BIAS = 765;
  // divide by six as multiply by 683 and shift by 12, exact below 1536
  localparam int RECIP_W  = 10;
  localparam int RECIP    = 683;
  localparam int RECIP_SH = 12;
  localparam int PROD_W   = SUM_W + RECIP_W;

endpackage

### rtl/emb3_if.sv
`timescale 1ns / 1ps
interface emb3_in_if import emb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface emb3_out_if import emb3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_pixel;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;

  modport source (output valid, output out_pixel, output out_row, output out_col,
                  input ready);
  modport sink   (input valid, input out_pixel, input out_row, input out_col,
                  output ready);
endinterface

### rtl/emboss_3x3_image_filter.sv
`timescale 1ns / 1ps
// path: an item waits in the s1 registers, then its result is registered on out_o
// throughput: one item per cycle unless out_o stalls, set by the single line store
//   ram with one read and one write port, read at accept, written back as s1 fires
// reset: row/column counters, valid flags and line_width (640) are cleared
//   at once; the line store is not cleared and needs no clearing pass
module emboss_3x3_image_filter import emb3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  emb3_in_if.sink          in_i,
  emb3_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

`include "emboss_3x3_image_filter_defines.svh"

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_LINES);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r < RW'(MAX_LINES - 1)) ? r + RW'(1) : r;
  endfunction

  logic [CFG_W-1:0]  line_width_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;

  logic              s1_valid_q;
  logic [AW-1:0]     s1_c_q;
  logic [RW-1:0]     s1_row_q;
  logic [PIX_W-1:0]  s1_px_q;
  logic              s1_emit_q;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_data_q;

  logic [PIX_W-1:0]  wr0_q, wr1_q, wr2_q, wr3_q, wr5_q;

  logic               out_valid_q;
  logic [PIX_W-1:0]   out_pixel_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;

  logic [CMPW-1:0]   eff_w;
  logic [CW-1:0]     acc_c;
  logic [RW-1:0]     acc_row;
  logic              acc_emit;
  logic              in_acc;
  logic              s1_fire;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] up_eff;
  logic [LINE_W-1:0] wb_data;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [AW-1:0]     col_m1;
  logic [RW-1:0]     row_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (line_width_q < CFG_W'(MIN_WIDTH)) begin
      eff_w = CMPW'(MIN_WIDTH);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = CMPW'(line_width_q);
    end
  end

  // column and row of the incoming item, and the counts after it
  always_comb begin
    logic [CW-1:0] cn;
    if (in_i.frame_start) begin
      acc_c   = '0;
      acc_row = '0;
    end else if (CMPW'(col_q) >= eff_w) begin
      acc_c   = '0;
      acc_row = row_inc(row_q);
    end else begin
      acc_c   = col_q;
      acc_row = row_q;
    end
    acc_emit = (acc_row >= RW'(2)) && (acc_c >= CW'(2));
    cn = acc_c + CW'(1);
    if (CMPW'(cn) >= eff_w) begin
      col_d = '0;
      row_d = row_inc(acc_row);
    end else begin
      col_d = cn;
      row_d = acc_row;
    end
  end

  assign s1_fire  = s1_valid_q && (!s1_emit_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= s1_valid_q && (s1_c_q == acc_c[AW-1:0]);
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_c_q     <= acc_c[AW-1:0];
      s1_row_q   <= acc_row;
      s1_px_q    <= in_i.pixel;
      s1_emit_q  <= acc_emit;
      fwd_data_q <= wb_data;
    end
  end

  emb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_c_q),
    .wdata_i (wb_data),
    .re_i    (in_acc),
    .raddr_i (acc_c[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // upper byte is two rows up, lower byte one row up
  assign up_eff  = fwd_q ? fwd_data_q : ram_rdata;
  assign wb_data = {up_eff[PIX_W-1:0], s1_px_q};

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      wr0_q <= wr1_q;
      wr1_q <= up_eff[LINE_W-1:PIX_W];
      wr2_q <= wr3_q;
      wr3_q <= up_eff[PIX_W-1:0];
      wr5_q <= s1_px_q;
    end
  end

  assign sum = SUM_W'(s1_px_q) + SUM_W'(up_eff[PIX_W-1:0]) + SUM_W'(wr5_q)
             + SUM_W'(EMB_BIAS) - SUM_W'(wr0_q) - SUM_W'(wr1_q) - SUM_W'(wr2_q);
  assign prod   = PROD_W'(sum) * PROD_W'(RECIP);
  assign col_m1 = s1_c_q - AW'(1);
  assign row_m1 = s1_row_q - RW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out_pixel_q <= prod[RECIP_SH +: PIX_W];
      out_row_q   <= COORD_W'(row_m1);
      out_col_q   <= COORD_W'(col_m1);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_pixel_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;

  `EMB3_ASSERT(a_fwd_only_col0, clk_i, rst_ni, (fwd_q && s1_valid_q) |-> (s1_c_q == '0))
  `EMB3_ASSERT(a_col_bound, clk_i, rst_ni, 32'(col_q) <= MAX_WIDTH - 1)
  `EMB3_ASSERT(a_row_bound, clk_i, rst_ni, 32'(row_q) <= MAX_LINES - 1)
  `EMB3_ASSERT(a_s1_hold, clk_i, rst_ni,
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_c_q) && $stable(s1_px_q)))

endmodule

### rtl/emb3_line_ram.sv
`timescale 1ns / 1ps
module emb3_line_ram import emb3_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [LINE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [LINE_W-1:0] rdata_o
);

  logic [LINE_W-1:0] line_mem_q [DEPTH];
  logic [LINE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      line_mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= line_mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
